### sv/assert_macros.svh
// Assertion macros shared by the RTL of the weighted sum block.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WEWS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define WEWS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed during reset");
`else
`define WEWS_ASSERT(lbl, clk, rst, prop)
`define WEWS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

### sv/wews_pkg.sv
// Types, constants and the saturation helper of the weighted sum block.
// No dependencies; used by the controller, datapath and top level.
package wews_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 64;
  localparam int FRAC_W    = 16;
  localparam int DECAY_W   = 16;
  localparam int WEIGHT_W  = 17;
  localparam int WLEN_W    = 9;
  localparam int OUT_W     = 48;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int EXT_W     = 67;
  localparam int LEAVE_W   = SAMPLE_W + WEIGHT_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd2;

  localparam logic [DECAY_W-1:0]  DECAY_RST  = 16'd63188;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd32768;
  localparam logic [WLEN_W-1:0]   WLEN_RST   = 9'd0;

  typedef struct packed {
    logic load;
    logic leave;
    logic sub;
    logic mul;
    logic acc;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [SUM_W-1:0] val;
    logic             clip;
  } sat_t;

  // clamp a wide signed sum to the signed 64-bit range
  function automatic sat_t sat_clamp(input logic [EXT_W-1:0] v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = v[SUM_W-1:0];
    if (!v[EXT_W-1] && (v[EXT_W-2:SUM_W-1] != '0)) begin
      r.clip = 1'b1;
      r.val  = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (v[EXT_W-1] && (v[EXT_W-2:SUM_W-1] != '1)) begin
      r.clip = 1'b1;
      r.val  = {1'b1, {(SUM_W-1){1'b0}}};
    end
    return r;
  endfunction

endpackage

### sv/wews_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read of the address being written returns the old contents.
module wews_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/wews_ctrl.sv
// Sequencing controller of the weighted sum block.
// Depends on wews_pkg and assert_macros.svh; drives the datapath commands.
`include "assert_macros.svh"
module wews_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  wews_pkg::status_t status,
  output wews_pkg::cmd_t    cmd
);
  import wews_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LEAVE = 5'b00010,
    S_SUB   = 5'b00100,
    S_MUL   = 5'b01000,
    S_ACC   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_LEAVE;
      end
      S_LEAVE: state_next = S_SUB;
      S_SUB:   state_next = S_MUL;
      S_MUL:   state_next = S_ACC;
      S_ACC: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready  = (state == S_IDLE) && !rst;
  assign cmd.load  = s_tready && s_tvalid;
  assign cmd.leave = (state == S_LEAVE);
  assign cmd.sub   = (state == S_SUB);
  assign cmd.mul   = (state == S_MUL);
  assign cmd.acc   = (state == S_ACC) && status.out_free;

  `WEWS_ASSERT(a_load_to_leave, clk, rst, cmd.load |=> state == S_LEAVE)
  `WEWS_ASSERT(a_acc_to_idle, clk, rst, cmd.acc |=> state == S_IDLE)
  `WEWS_ASSERT_RST(a_reset_idle, clk, rst |=> state == S_IDLE)

endmodule

### sv/wews_dp.sv
// Datapath: config registers, sample ring, decay multiplier, accumulators
// and output register. Depends on wews_pkg, wews_ram and assert_macros.svh.
`include "assert_macros.svh"
module wews_dp #(
  parameter int WINDOW_MAX = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wews_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wews_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [wews_pkg::SAMPLE_W-1:0] sample,
  input  wews_pkg::cmd_t                      cmd,
  output wews_pkg::status_t                   status,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wews_pkg::OUT_W-1:0]          m_tdata,
  output logic                                m_tuser
);
  import wews_pkg::*;

  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int NW = $clog2(WINDOW_MAX + 1);

  logic [DECAY_W-1:0]  decay;
  logic [WEIGHT_W-1:0] end_weight;
  logic [WLEN_W-1:0]   win_len;

  logic [SUM_W-1:0]    main_sum;
  logic [SUM_W-1:0]    restart_sum;
  logic [NW-1:0]       restart_count;
  logic [NW-1:0]       ring_fill;
  logic [IW-1:0]       wr_idx;
  logic                clip_main;
  logic                use_leave;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [LEAVE_W-1:0]  leave_prod;
  logic signed [LEAVE_W-1:0]  leave_mul;
  logic [47:0]         rs_lo_p, mn_lo_p;
  logic signed [48:0]  rs_hi_p, mn_hi_p;

  logic                finite;
  logic [NW-1:0]       n;
  logic [NW:0]         wr_ext, n_ext, old_full;
  logic [SAMPLE_W-1:0] ring_q;
  logic                ring_we;
  logic [SUM_W-1:0]    mul_x;
  logic [47:0]         lo_p;
  logic signed [48:0]  hi_p;
  logic [EXT_W-1:0]    entry_ext, sub_sum, main_comb, rs_comb;
  sat_t                sub_sat, main_sat, rs_sat;
  logic [NW-1:0]       count_inc;
  logic [SUM_W-1:0]    main_new;
  logic                clip_new;

  assign finite = (win_len >= WLEN_W'(2));
  assign n = (int'(win_len) > WINDOW_MAX) ? NW'(WINDOW_MAX) : NW'(win_len);

  // oldest ring slot: write index minus n, modulo the ring depth
  assign wr_ext   = (NW+1)'(wr_idx);
  assign n_ext    = (NW+1)'(n);
  assign old_full = (wr_ext >= n_ext) ? (wr_ext - n_ext)
                                      : (wr_ext + (NW+1)'(WINDOW_MAX) - n_ext);
  assign ring_we  = cmd.load && finite;

  wews_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW_MAX)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(wr_idx),
    .wdata(sample),
    .raddr(old_full[IW-1:0]),
    .rdata(ring_q)
  );

  // shared decay multiplier, split at bit 32
  assign mul_x = cmd.leave ? restart_sum : main_sum;
  assign lo_p  = mul_x[31:0] * decay;
  assign hi_p  = $signed(mul_x[63:32]) * $signed({1'b0, decay});

  assign leave_mul = $signed(ring_q) * $signed({1'b0, end_weight});

  assign entry_ext = {{35{sample_q[SAMPLE_W-1]}}, sample_q, {FRAC_W{1'b0}}};
  assign sub_sum   = {{3{main_sum[SUM_W-1]}}, main_sum}
                   - {{(EXT_W-LEAVE_W){leave_prod[LEAVE_W-1]}}, leave_prod};
  assign main_comb = {{2{mn_hi_p[48]}}, mn_hi_p, {FRAC_W{1'b0}}}
                   + {35'b0, mn_lo_p[47:16]} + entry_ext;
  assign rs_comb   = {{2{rs_hi_p[48]}}, rs_hi_p, {FRAC_W{1'b0}}}
                   + {35'b0, rs_lo_p[47:16]} + entry_ext;
  assign sub_sat   = sat_clamp(sub_sum);
  assign main_sat  = sat_clamp(main_comb);
  assign rs_sat    = sat_clamp(rs_comb);
  assign count_inc = restart_count + NW'(1);

  always_comb begin
    main_new = main_sat.val;
    clip_new = clip_main | main_sat.clip;
    if (finite && (count_inc == n)) begin
      main_new = rs_sat.val;
      clip_new = clip_main | main_sat.clip | rs_sat.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decay         <= DECAY_RST;
      end_weight    <= WEIGHT_RST;
      win_len       <= WLEN_RST;
      main_sum      <= '0;
      restart_sum   <= '0;
      restart_count <= '0;
      ring_fill     <= '0;
      wr_idx        <= '0;
      m_tvalid      <= 1'b0;
    end else if (cfg_we && (cfg_index == REG_DECAY || cfg_index == REG_END_WEIGHT
                            || cfg_index == REG_WINDOW)) begin
      case (cfg_index)
        REG_DECAY:      decay      <= cfg_data[DECAY_W-1:0];
        REG_END_WEIGHT: end_weight <= cfg_data[WEIGHT_W-1:0];
        REG_WINDOW:     win_len    <= cfg_data[WLEN_W-1:0];
        default: ;
      endcase
      main_sum      <= '0;
      restart_sum   <= '0;
      restart_count <= '0;
      ring_fill     <= '0;
      wr_idx        <= '0;
    end else begin
      if (cmd.load && finite) begin
        wr_idx <= (wr_idx == IW'(WINDOW_MAX - 1)) ? '0 : wr_idx + IW'(1);
        if (ring_fill < n) ring_fill <= ring_fill + NW'(1);
      end
      if (cmd.sub) begin
        main_sum <= sub_sat.val;
      end
      if (cmd.acc) begin
        main_sum <= main_new;
        if (finite) begin
          if (count_inc == n) begin
            restart_sum   <= '0;
            restart_count <= '0;
          end else begin
            restart_sum   <= rs_sat.val;
            restart_count <= count_inc;
          end
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q  <= sample;
      use_leave <= finite && (ring_fill >= n);
      clip_main <= 1'b0;
    end
    if (cmd.leave) begin
      leave_prod <= use_leave ? leave_mul : '0;
      rs_lo_p    <= lo_p;
      rs_hi_p    <= hi_p;
    end
    if (cmd.sub) begin
      clip_main <= sub_sat.clip;
    end
    if (cmd.mul) begin
      mn_lo_p <= lo_p;
      mn_hi_p <= hi_p;
    end
    if (cmd.acc) begin
      m_tdata <= main_new[SUM_W-1:FRAC_W];
      m_tuser <= clip_new;
    end
  end

  assign status.out_free = !m_tvalid || m_tready;

  `WEWS_ASSERT(a_count_below_n, clk, rst, finite |-> restart_count < n)
  `WEWS_ASSERT(a_infinite_no_restart, clk, rst, !finite |-> restart_sum == '0)
  `WEWS_ASSERT(a_valid_from_acc, clk, rst, $rose(m_tvalid) |-> $past(cmd.acc))

endmodule

### sv/windowed_exponential_weighted_sum.sv
// Exponentially weighted moving sum, optionally over a finite window of the
// last N samples. One result per sample; a sample's result lands in the output
// register at the end of its accumulate step; the next sample is taken only
// after that step, so samples are processed one at a time. The sample pace is
// set by the chain on the fed-back sum: ring read, oldest-sample product,
// subtract, decay product through one shared multiplier, and the final
// accumulate. A finished result waits in the output register; the next sample
// is taken meanwhile and holds in its accumulate step until that register
// frees. s_tready is low during reset. No clearing pass is needed after reset;
// any register write clears the sums and the window. Depends on wews_pkg,
// wews_ctrl, wews_dp.
module windowed_exponential_weighted_sum #(
  parameter int WINDOW_MAX = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wews_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wews_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [wews_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [wews_pkg::OUT_W-1:0]     m_tdata,   // [47:0] weighted_sum
  output logic                           m_tuser    // [0] saturated
);
  import wews_pkg::*;

  cmd_t    cmd;
  status_t status;

  wews_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  wews_dp #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sample   ($signed(s_tdata)),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### tb/windowed_exponential_weighted_sum_tb.sv
`timescale 1ns / 1ps
// Testbench for windowed_exponential_weighted_sum: drives samples through the
// stream ports, predicts each weighted sum in fixed point and checks results.
// Depends on wews_pkg and the block's RTL.
module windowed_exponential_weighted_sum_tb;
  import wews_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_CYCLES = 300;

  typedef struct {
    logic signed [OUT_W-1:0] wsum;
    logic                    sat;
  } sum_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;   // [15:0] sample
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;        // [47:0] weighted_sum
  logic                  m_tuser;        // [0] saturated

  windowed_exponential_weighted_sum i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and state
  logic [DECAY_W-1:0]         decay_q = DECAY_RST;
  logic [WEIGHT_W-1:0]        endw_q = WEIGHT_RST;
  logic [WLEN_W-1:0]          wlen_q = WLEN_RST;
  longint                     main_acc, restart_acc;
  logic [WLEN_W-1:0]          restart_cnt, ring_count;
  logic [7:0]                 ring_wr;
  logic signed [SAMPLE_W-1:0] sample_window [RING_DEPTH];

  logic [SAMPLE_W-1:0] pending_samples[$];
  sum_result_t         expected_sums[$];
  int  queued_total = 0, accepted_total = 0, results_checked = 0, errors = 0;
  int  settings_used = 1;
  int  send_idle_pct = 0, rcv_idle_pct = 0;
  int  stall_reqs = 0, stall_seen = 0, stall_cnt = 0;
  int  cycle_count = 0;
  bit  in_xfer = 1'b0;

  function automatic void clear_sums();
    main_acc = 0;
    restart_acc = 0;
    restart_cnt = '0;
    ring_count = '0;
    ring_wr = '0;
    for (int i = 0; i < RING_DEPTH; i++) sample_window[i] = '0;
  endfunction

  function automatic longint sat_add64(input longint a, input longint b, inout bit clip);
    logic [65:0] s;
    s = {{2{a[63]}}, a} + {{2{b[63]}}, b};
    if (s[65:63] != 3'b000 && s[65:63] != 3'b111) begin
      clip = 1'b1;
      return s[65] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // floor(x * d / 2^16), exact
  function automatic longint decay_mul(input longint x, input logic [DECAY_W-1:0] d);
    logic [81:0] p;
    p = {{18{x[63]}}, x} * {66'd0, d};
    return p[79:16];
  endfunction

  function automatic sum_result_t predict_sum(input logic [SAMPLE_W-1:0] raw);
    sum_result_t r;
    longint entry, leaving;
    int n;
    bit finite, clip_main, clip_restart;
    entry = longint'($signed(raw)) * 65536;
    finite = wlen_q >= 2;
    n = (wlen_q > RING_DEPTH) ? RING_DEPTH : int'(wlen_q);
    clip_main = 1'b0;
    clip_restart = 1'b0;
    if (finite && ring_count >= n) begin
      leaving = longint'(sample_window[8'(ring_wr - n[7:0])]) * longint'(endw_q);
      main_acc = sat_add64(main_acc, -leaving, clip_main);
    end
    main_acc = sat_add64(decay_mul(main_acc, decay_q), entry, clip_main);
    if (finite) begin
      restart_cnt = restart_cnt + 1'b1;
      restart_acc = sat_add64(decay_mul(restart_acc, decay_q), entry, clip_restart);
      if (restart_cnt == n) begin
        restart_cnt = '0;
        main_acc = restart_acc;
        clip_main = clip_main | clip_restart;
        restart_acc = 0;
      end
      sample_window[ring_wr] = $signed(raw);
      ring_wr = ring_wr + 1'b1;
      if (ring_count < n) ring_count = ring_count + 1'b1;
    end
    r.wsum = main_acc[63:16];
    r.sat = clip_main;
    return r;
  endfunction

  // decay^(n-1) in Q1.16, the matched end weight
  function automatic logic [WEIGHT_W-1:0] end_weight_for(input int decay, input int n);
    longint w;
    w = 65536;
    for (int i = 1; i < n; i++) w = (w * decay) >>> 16;
    return w[WEIGHT_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 31)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  // input side: sample transfers feed the predictor
  always @(posedge clk) begin
    in_xfer = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      in_xfer = 1'b1;
      accepted_total++;
      expected_sums.push_back(predict_sum(s_tdata));
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_xfer) begin
      if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tdata <= pending_samples.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long output hold-off, started on request
  always @(posedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
    end else if (stall_seen != stall_reqs) begin
      stall_seen <= stall_reqs;
      stall_cnt <= STALL_CYCLES;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (stall_cnt == 0) && ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sum_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result transfer: weighted_sum %0d", $signed(m_tdata));
        errors++;
      end else begin
        want = expected_sums.pop_front();
        results_checked++;
        if ($signed(m_tdata) !== want.wsum) begin
          $error("weighted_sum: expected %0d, got %0d", want.wsum, $signed(m_tdata));
          errors++;
        end
        if (m_tuser !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_sums.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_total != queued_total || expected_sums.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_profile(input int send_pct, input int rcv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    rcv_idle_pct = rcv_pct;
  endtask

  task automatic queue_sample(input logic [SAMPLE_W-1:0] smp);
    pending_samples.push_back(smp);
    queued_total++;
  endtask

  task automatic queue_random(input int count);
    @(posedge clk);
    for (int i = 0; i < count; i++) queue_sample(rand_sample());
  endtask

  // writes all three registers while idle; each write clears the block
  task automatic load_settings(input int decay, input int endw, input int wlen);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_DECAY;
    cfg_data <= CFG_W'(decay);
    @(negedge clk);
    cfg_index <= REG_END_WEIGHT;
    cfg_data <= CFG_W'(endw);
    @(negedge clk);
    cfg_index <= REG_WINDOW;
    cfg_data <= CFG_W'(wlen);
    @(negedge clk);
    cfg_we <= 1'b0;
    decay_q = DECAY_W'(decay);
    endw_q = WEIGHT_W'(endw);
    wlen_q = WLEN_W'(wlen);
    clear_sums();
    settings_used++;
  endtask

  initial begin
    int decay;
    clear_sums();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings (infinite window), decay of zero with the
    // shortest window, then an end weight well off decay^(N-1)
    set_profile(27, 75);
    queue_sample(16'h7FFF); queue_sample(16'h7FFF); queue_sample(16'h8000);
    queue_sample(16'h8000); queue_sample(16'h0000); queue_sample(16'hFFFF);
    load_settings(0, 0, 2);
    @(posedge clk);
    queue_sample(16'h7FFF); queue_sample(16'h8000); queue_sample(16'h7FFF);
    queue_sample(16'h8000); queue_sample(16'h0001); queue_sample(16'hFFFF);
    load_settings(65535, 131071, 3);
    @(posedge clk);
    repeat (5) queue_sample(16'h8000);
    repeat (2) queue_sample(16'h7FFF);

    // random phases
    load_settings(65535, 65536, 1);
    queue_random(80);
    load_settings($urandom_range(1, 65535), $urandom_range(0, 131071), 2);
    queue_random(100);

    load_settings(1, 1, 5);
    set_profile(75, 27);
    queue_random(100);
    decay = $urandom_range(40000, 65535);
    load_settings(decay, end_weight_for(decay, 17), 17);
    queue_random(150);

    load_settings(63188, end_weight_for(63188, 256), 256);
    set_profile(0, 0);
    @(negedge clk);
    stall_reqs++;
    queue_random(320);
    load_settings(0, 131071, 511);
    queue_random(300);

    wait_drained();
    $display("checked %0d results from %0d samples across %0d register settings",
             results_checked, accepted_total, settings_used);
    $display("windows: infinite, 2, 3, 5, 17, 256 and 511 (clipped); one long output stall");
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/wews_pkg.sv
sv/wews_ram.sv
sv/wews_ctrl.sv
sv/wews_dp.sv
sv/windowed_exponential_weighted_sum.sv
tb/windowed_exponential_weighted_sum_tb.sv
